// ===== src/psbb_pkg.sv =====
package psbb_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int CHANNEL_BITS = 8;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int FW_W    = 11;
  localparam int FH_W    = 13;
  localparam int PIX_W   = 3 * CHANNEL_BITS;
  localparam int TDATA_W = ((PIX_W + 7) / 8) * 8;
  localparam int SUM_W   = CHANNEL_BITS + 3;
  localparam int CNT_W   = 3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [FW_W-1:0] FW_RESET = 11'd640;
  localparam logic [FH_W-1:0] FH_RESET = 13'd480;

  // Reciprocal constants: floor(2^S / d) + 1 keeps the truncated quotient
  // exact for every sum below 2^SUM_W.
  localparam int DIV3_SH = SUM_W + 2;
  localparam int DIV5_SH = SUM_W + 3;
  localparam int PROD_W  = SUM_W + DIV5_SH;
  localparam logic [PROD_W-1:0] DIV3_MUL = PROD_W'((1 << DIV3_SH) / 3 + 1);
  localparam logic [PROD_W-1:0] DIV5_MUL = PROD_W'((1 << DIV5_SH) / 5 + 1);

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [SUM_W-1:0]        sum_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } pixel_t;

  // Neighborhood flags of the pixel at the current stream position
  typedef struct packed {
    logic row_ge1;
    logic row_ge2;
    logic col_ge1;
    logic col_ge2;
    logic has_right;
    logic last_row;
    logic frame_fin;
  } pos_t;

  typedef struct packed {
    pixel_t pix;
    logic   frame_end;
  } result_t;

  function automatic chan_t mean_chan(sum_t s, cnt_t n);
    logic [PROD_W-1:0] prod;
    sum_t              q;
    prod = '0;
    q    = '0;
    case (n)
      3'd2: q = s >> 1;
      3'd3: begin
        prod = PROD_W'(s) * DIV3_MUL;
        q    = SUM_W'(prod >> DIV3_SH);
      end
      3'd4: q = s >> 2;
      3'd5: begin
        prod = PROD_W'(s) * DIV5_MUL;
        q    = SUM_W'(prod >> DIV5_SH);
      end
      default: q = '0;
    endcase
    return chan_t'(q);
  endfunction

  // Mean of the enabled terms, channel by channel
  function automatic pixel_t blur_px(pixel_t [4:0] t, logic [4:0] en);
    sum_t   sr;
    sum_t   sg;
    sum_t   sb;
    cnt_t   n;
    pixel_t o;
    sr = '0;
    sg = '0;
    sb = '0;
    for (int i = 0; i < 5; i++) begin
      if (en[i]) begin
        sr = sr + SUM_W'(t[i].red);
        sg = sg + SUM_W'(t[i].green);
        sb = sb + SUM_W'(t[i].blue);
      end
    end
    n       = CNT_W'($countones(en));
    o.red   = mean_chan(sr, n);
    o.green = mean_chan(sg, n);
    o.blue  = mean_chan(sb, n);
    return o;
  endfunction

endpackage

// ===== src/psbb_ctrl.sv =====
module psbb_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [psbb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psbb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              adv,
  output logic [psbb_pkg::COL_W-1:0]        col,
  output psbb_pkg::pos_t                    pos
);
  import psbb_pkg::*;

  logic [FW_W-1:0]  fw_r;
  logic [FH_W-1:0]  fh_r;
  logic [FW_W-1:0]  eff_w;
  logic [FH_W-1:0]  eff_h;
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] row_nxt;
  logic             col_end;
  logic             last_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FW_RESET;
      fh_r <= FH_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  fw_r <= cfg_wdata[FW_W-1:0];
        REG_FRAME_HEIGHT: fh_r <= cfg_wdata[FH_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (fw_r < FW_W'(2)) begin
      eff_w = FW_W'(2);
    end else if (32'(fw_r) > 32'(MAX_WIDTH)) begin
      eff_w = FW_W'(MAX_WIDTH);
    end else begin
      eff_w = fw_r;
    end
    if (fh_r < FH_W'(2)) begin
      eff_h = FH_W'(2);
    end else if (32'(fh_r) > 32'(MAX_HEIGHT)) begin
      eff_h = FH_W'(MAX_HEIGHT);
    end else begin
      eff_h = fh_r;
    end
  end

  // A count at or past the last index wraps, so compare with >=
  assign col_end  = (32'(col_r) + 32'd1) >= 32'(eff_w);
  assign last_row = (32'(row_r) + 32'd1) >= 32'(eff_h);

  assign col           = col_r;
  assign pos.row_ge1   = (row_r != '0);
  assign pos.row_ge2   = (row_r >= ROW_W'(2));
  assign pos.col_ge1   = (col_r != '0);
  assign pos.col_ge2   = (col_r >= COL_W'(2));
  assign pos.has_right = !col_end;
  assign pos.last_row  = last_row;
  assign pos.frame_fin = last_row && col_end;

  always_comb begin
    col_nxt = col_r + COL_W'(1);
    row_nxt = row_r;
    if (col_end) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (adv) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== src/psbb_line_buf.sv =====
module psbb_line_buf (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [psbb_pkg::COL_W-1:0]   rd_col,
  input  logic                         wr_en,
  input  logic [psbb_pkg::COL_W-1:0]   wr_col,
  input  psbb_pkg::pixel_t             wr_mid,
  output psbb_pkg::pixel_t             up_q,
  output psbb_pkg::pixel_t             mid_q,
  output psbb_pkg::pixel_t             mid_right_q
);
  import psbb_pkg::*;

  pixel_t           upper_mem  [MAX_WIDTH];
  pixel_t           middle_mem [MAX_WIDTH];
  pixel_t           up_r;
  pixel_t           mid_r;
  pixel_t           mid_right_r;
  logic [COL_W-1:0] rd_right;

  assign rd_right = rd_col + COL_W'(1);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_r  <= upper_mem[rd_col];
      mid_r <= middle_mem[rd_col];
      // On a two-pixel row the right neighbor is being written this cycle
      if (wr_en && (wr_col == rd_right)) begin
        mid_right_r <= wr_mid;
      end else begin
        mid_right_r <= middle_mem[rd_right];
      end
    end
  end

  // Shift the column down one line: old middle entry moves to the upper line
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_col]  <= mid_r;
      middle_mem[wr_col] <= wr_mid;
    end
  end

  assign up_q        = up_r;
  assign mid_q       = mid_r;
  assign mid_right_q = mid_right_r;

endmodule

// ===== src/psbb_out_q.sv =====
module psbb_out_q (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic [2:0]                    load_mask,
  input  psbb_pkg::result_t [2:0]       load_res,
  output logic                          room,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [psbb_pkg::TDATA_W-1:0]  out_tdata,
  output logic                          out_tlast
);
  import psbb_pkg::*;

  logic [2:0]    mask_r;
  logic [2:0]    mask_nxt;
  logic [2:0]    lowest;
  result_t [2:0] ent_r;
  result_t       sel;
  logic          pop;

  assign out_tvalid = |mask_r;
  assign pop        = out_tvalid && out_tready;
  assign room       = (mask_r == '0) || (out_tready && $onehot(mask_r));
  assign lowest     = mask_r & (~mask_r + 3'd1);

  always_comb begin
    if (mask_r[0]) begin
      sel = ent_r[0];
    end else if (mask_r[1]) begin
      sel = ent_r[1];
    end else begin
      sel = ent_r[2];
    end
  end

  assign out_tdata = TDATA_W'(sel.pix);
  assign out_tlast = sel.frame_end;

  always_comb begin
    mask_nxt = mask_r;
    if (load) begin
      mask_nxt = load_mask;
    end else if (pop) begin
      mask_nxt = mask_r & ~lowest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= load_res;
    end
  end

  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> room)
    else $error("result bundle loaded over pending results");

  a_pending_stay: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !$onehot(mask_r) |=> out_tvalid)
    else $error("pending results dropped after a transfer");

endmodule

// ===== src/plus_stencil_box_blur.sv =====
// Five-point mean blur over an RGB frame streamed in raster order.
// Input channel in_*: one pixel per transfer, in_tdata = red, green, blue.
// Output channel out_*: blurred pixels in raster order; out_tlast marks the
// final pixel of the frame. Frame size comes from the cfg_* write port
// (index 0 frame width, index 1 frame height); write it only while idle.
// Each output pixel is the truncated mean of the pixel and its in-frame
// up/down/left/right neighbors. A pixel leaves once its lower neighbor has
// arrived, so rows come out one row late; last-row pixels come out one pixel
// late, and the final input pixel also releases the final output pixel.
// A result is computed from the input register and held in the result
// register until it leaves. Throughput: one pixel per cycle while out_tready
// stays high, set by the single-pass stencil between the input and result
// registers; on the last row each input past column 0 releases two results,
// so the output port holds back the next pixel, and the final pixel releases
// three. Reset clears the position counters and the output register; line
// buffer contents are not cleared. When out_tready is low, the result register
// holds and in_tready drops once a pixel with results fills the input register.
module plus_stencil_box_blur (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [psbb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psbb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [psbb_pkg::TDATA_W-1:0]      in_tdata,   // in_red, in_green, in_blue
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [psbb_pkg::TDATA_W-1:0]      out_tdata,  // out_red, out_green, out_blue
  output logic                              out_tlast
);
  import psbb_pkg::*;

  logic             in_accept;
  logic [COL_W-1:0] col;
  pos_t             pos;
  pixel_t           in_pix;

  logic             s1_valid_r;
  pixel_t           s1_pix_r;
  pos_t             s1_pos_r;
  logic [COL_W-1:0] s1_col_r;
  pixel_t           mid_prev_r;
  pixel_t           pix_prev_r;
  pixel_t           pix_prev2_r;
  logic             s1_fire;

  pixel_t           up_q;
  pixel_t           mid_q;
  pixel_t           mid_right_q;

  logic [2:0]       res_mask;
  result_t [2:0]    res;
  logic             q_room;
  logic             q_load;

  assign in_pix    = pixel_t'(in_tdata[PIX_W-1:0]);
  assign in_accept = in_tvalid && in_tready;
  assign in_tready = !s1_valid_r || s1_fire;

  psbb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .adv       (in_accept),
    .col       (col),
    .pos       (pos)
  );

  psbb_line_buf u_line_buf (
    .clk         (clk),
    .rd_en       (in_accept),
    .rd_col      (col),
    .wr_en       (s1_fire),
    .wr_col      (s1_col_r),
    .wr_mid      (s1_pix_r),
    .up_q        (up_q),
    .mid_q       (mid_q),
    .mid_right_q (mid_right_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  // The input register still holds the previous column while the next loads
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix_r    <= in_pix;
      s1_pos_r    <= pos;
      s1_col_r    <= col;
      mid_prev_r  <= mid_q;
      pix_prev_r  <= s1_pix_r;
      pix_prev2_r <= pix_prev_r;
    end
  end

  // Result 0: pixel one row up. Result 1: last-row pixel one column left.
  // Result 2: bottom-right corner.
  assign res_mask = {s1_pos_r.frame_fin,
                     s1_pos_r.last_row && s1_pos_r.col_ge1,
                     s1_pos_r.row_ge1};

  assign res[0].pix = blur_px({mid_right_q, mid_prev_r, up_q, s1_pix_r, mid_q},
                              {s1_pos_r.has_right, s1_pos_r.col_ge1,
                               s1_pos_r.row_ge2, 1'b1, 1'b1});
  assign res[0].frame_end = 1'b0;

  assign res[1].pix = blur_px({s1_pix_r, pix_prev2_r, s1_pix_r, mid_prev_r, pix_prev_r},
                              {1'b0, s1_pos_r.col_ge2, 1'b1, 1'b1, 1'b1});
  assign res[1].frame_end = 1'b0;

  assign res[2].pix = blur_px({s1_pix_r, s1_pix_r, pix_prev_r, mid_q, s1_pix_r},
                              {1'b0, 1'b0, s1_pos_r.col_ge1, 1'b1, 1'b1});
  assign res[2].frame_end = 1'b1;

  // First-row pixels release nothing and pass without waiting for room
  assign s1_fire = s1_valid_r && (q_room || (res_mask == '0));
  assign q_load  = s1_fire && (res_mask != '0);

  psbb_out_q u_out_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (q_load),
    .load_mask  (res_mask),
    .load_res   (res),
    .room       (q_room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_valid_r)
    else $error("accepted pixel missing from input register");

  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && !q_room && (res_mask != '0))
    else $error("input stalled without a blocked result");

  a_final_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_pos_r.frame_fin |=> out_tvalid)
    else $error("frame end released no result");

endmodule
